### hdl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// shared widths and constants for the quaternion to rotation matrix core
// ----------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

  localparam int COMP_W    = 16;             // quaternion component width
  localparam int PROD_W    = 2 * COMP_W;     // one product of two components
  localparam int NORM_W    = PROD_W + 1;     // sum of four squares
  localparam int NUM_W     = PROD_W + 2;     // signed numerator, off-diagonal doubled
  localparam int ENTRY_W   = 16;             // matrix entry width, Q2.14
  localparam int QUO_W     = ENTRY_W;        // quotient of num * 2^15 / n
  localparam int DIV_STEPS = QUO_W;          // one quotient bit per stage
  localparam int ENTRIES   = 9;

  localparam logic signed [ENTRY_W-1:0] Q_ONE = 16'sd16384;

  // latency: product, sum, magnitude, divide steps, rounding
  localparam int LATENCY = 3 + DIV_STEPS + 1;

  typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

### hdl/quaternion_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// quaternion (x, y, z, w) to the nine entries of its 3x3 rotation matrix
// ----------------------------------------------------------------------------
// One input word carries quat_x, quat_y, quat_z, quat_w (signed 16 bit, any
// common scale). One output word carries the nine entries row1_col1 ..
// row3_col3 in Q2.14, rounded to nearest with ties away from zero, and
// zero_input, which is set when all four components are zero; that word
// then holds the identity matrix.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// The pipeline registers the ten products, then the sum of squares and the
// numerators, then sign and magnitude, then each step of the restoring
// divider (one quotient bit per stage, nine lanes sharing one divisor) and
// then the rounded result. A new word is taken every cycle unless stalled.
// When the receiver stalls a valid output word, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; no output word is shown until new input.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_rotation_matrix_core
  import qrm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COMP_W-1:0]  quat_x,
  input  wire logic signed [COMP_W-1:0]  quat_y,
  input  wire logic signed [COMP_W-1:0]  quat_z,
  input  wire logic signed [COMP_W-1:0]  quat_w,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [ENTRY_W-1:0]      row1_col1,
  output logic signed [ENTRY_W-1:0]      row1_col2,
  output logic signed [ENTRY_W-1:0]      row1_col3,
  output logic signed [ENTRY_W-1:0]      row2_col1,
  output logic signed [ENTRY_W-1:0]      row2_col2,
  output logic signed [ENTRY_W-1:0]      row2_col3,
  output logic signed [ENTRY_W-1:0]      row3_col1,
  output logic signed [ENTRY_W-1:0]      row3_col2,
  output logic signed [ENTRY_W-1:0]      row3_col3,
  output logic                           zero_input
);

  logic               adv;
  logic [LATENCY-1:0] vld;

  assign adv      = !(vld[LATENCY-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] p_xx, p_yy, p_zz, p_ww;
  logic signed [PROD_W-1:0] p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_ww <= quat_w * quat_w;
      p_xy <= quat_x * quat_y;
      p_xz <= quat_x * quat_z;
      p_yz <= quat_y * quat_z;
      p_wx <= quat_w * quat_x;
      p_wy <= quat_w * quat_y;
      p_wz <= quat_w * quat_z;
    end
  end

  // stage 2: sum of squares and numerators, off-diagonal ones doubled
  logic [NORM_W-1:0]        norm_next;
  logic signed [NUM_W-1:0]  pair_sum [ENTRIES];
  logic signed [NUM_W-1:0]  num_next [ENTRIES];
  logic [NORM_W-1:0]        norm;
  logic signed [NUM_W-1:0]  num [ENTRIES];

  always_comb begin
    norm_next = NORM_W'($unsigned(p_xx)) + NORM_W'($unsigned(p_yy))
              + NORM_W'($unsigned(p_zz)) + NORM_W'($unsigned(p_ww));
    pair_sum[0] = NUM_W'(p_xx) + NUM_W'(p_ww) - NUM_W'(p_yy) - NUM_W'(p_zz);
    pair_sum[1] = NUM_W'(p_xy) + NUM_W'(p_wz);
    pair_sum[2] = NUM_W'(p_xz) - NUM_W'(p_wy);
    pair_sum[3] = NUM_W'(p_xy) - NUM_W'(p_wz);
    pair_sum[4] = NUM_W'(p_yy) + NUM_W'(p_ww) - NUM_W'(p_xx) - NUM_W'(p_zz);
    pair_sum[5] = NUM_W'(p_yz) + NUM_W'(p_wx);
    pair_sum[6] = NUM_W'(p_xz) + NUM_W'(p_wy);
    pair_sum[7] = NUM_W'(p_yz) - NUM_W'(p_wx);
    pair_sum[8] = NUM_W'(p_zz) + NUM_W'(p_ww) - NUM_W'(p_xx) - NUM_W'(p_yy);
    for (int e = 0; e < ENTRIES; e++) begin
      if (e == 0 || e == 4 || e == 8) begin
        num_next[e] = pair_sum[e];
      end else begin
        num_next[e] = pair_sum[e] <<< 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm <= norm_next;
      for (int e = 0; e < ENTRIES; e++) begin
        num[e] <= num_next[e];
      end
    end
  end

  // stage 3 feeds divider slot 0: sign, magnitude, divisor, zero flag
  logic [NORM_W-1:0] dv_den  [DIV_STEPS+1];
  logic              dv_zero [DIV_STEPS+1];
  logic              dv_neg  [DIV_STEPS+1][ENTRIES];
  logic [NORM_W-1:0] dv_rem  [DIV_STEPS+1][ENTRIES];
  logic [QUO_W-1:0]  dv_quo  [DIV_STEPS+1][ENTRIES];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0]  <= norm;
      dv_zero[0] <= (norm == '0);
      for (int e = 0; e < ENTRIES; e++) begin
        dv_neg[0][e] <= num[e][NUM_W-1];
        dv_rem[0][e] <= num[e][NUM_W-1] ? NORM_W'(-num[e]) : NORM_W'(num[e]);
        dv_quo[0][e] <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den[j]  <= dv_den[j-1];
        dv_zero[j] <= dv_zero[j-1];
      end
    end

    for (genvar e = 0; e < ENTRIES; e++) begin : g_lane
      logic [NORM_W:0] trial;
      logic            fits;

      assign trial = (j == 1) ? {1'b0, dv_rem[j-1][e]} : {dv_rem[j-1][e], 1'b0};
      assign fits  = (trial >= {1'b0, dv_den[j-1]});

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_neg[j][e] <= dv_neg[j-1][e];
          dv_rem[j][e] <= fits ? NORM_W'(trial - {1'b0, dv_den[j-1]})
                               : trial[NORM_W-1:0];
          dv_quo[j][e] <= {dv_quo[j-1][e][QUO_W-2:0], fits};
        end
      end
    end
  end

  // last stage: halve with rounding, restore sign, identity on zero input
  logic [QUO_W:0] rnd  [ENTRIES];
  entry_t         mag_q [ENTRIES];
  entry_t         res_next [ENTRIES];
  entry_t         res [ENTRIES];
  logic           zero_reg;

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      rnd[e]   = (QUO_W + 1)'(dv_quo[DIV_STEPS][e]) + (QUO_W + 1)'(1);
      mag_q[e] = rnd[e][QUO_W:1];
      if (dv_zero[DIV_STEPS]) begin
        res_next[e] = (e == 0 || e == 4 || e == 8) ? Q_ONE : '0;
      end else begin
        res_next[e] = dv_neg[DIV_STEPS][e] ? -mag_q[e] : mag_q[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_reg <= dv_zero[DIV_STEPS];
      for (int e = 0; e < ENTRIES; e++) begin
        res[e] <= res_next[e];
      end
    end
  end

  assign row1_col1  = res[0];
  assign row1_col2  = res[1];
  assign row1_col3  = res[2];
  assign row2_col1  = res[3];
  assign row2_col2  = res[4];
  assign row2_col3  = res[5];
  assign row3_col1  = res[6];
  assign row3_col2  = res[7];
  assign row3_col3  = res[8];
  assign zero_input = zero_reg;

endmodule

`default_nettype wire
